### sv/lruc_pkg.sv
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and codes for the LRU cache with periodic eviction.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam int KEY_W     = 14;
  localparam int VALUE_W   = 64;
  localparam int CAP_W     = 5;
  localparam int PERIOD_W  = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam int MOD_CNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVICT_PERIOD    = 8'd1;

  typedef struct packed {
    logic cfg_we;
    logic accept;
    logic periodic_evict;
    logic lookup;
    logic act;
    logic insert;
    logic mod_start;
    logic mod_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_get;
    logic hit;
    logic mod_last;
  } ctrl_sts_t;

endpackage

### sv/lruc_datapath.sv
// ----------------------------------------------------------------------------
// lruc_datapath
// Entry table, recency ranks, value memory, configuration registers, the
// operation counter and the bit-serial remainder unit for the period phase.
// ----------------------------------------------------------------------------
module lruc_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lruc_pkg::ctrl_cmd_t              ctl,
  output lruc_pkg::ctrl_sts_t              sts,
  input  logic [lruc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lruc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             cmd,
  input  logic [lruc_pkg::KEY_W-1:0]       key,
  input  logic signed [lruc_pkg::VALUE_W-1:0] value,
  output logic                             hit,
  output logic signed [lruc_pkg::VALUE_W-1:0] read_value
);
  import lruc_pkg::*;

  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  logic [CAP_W-1:0]    active_capacity;
  logic [PERIOD_W-1:0] evict_period;
  logic [PERIOD_W-1:0] op_count;
  logic [PERIOD_W-1:0] phase;
  logic [PERIOD_W-1:0] rem;
  logic [MOD_CNT_W-1:0] mod_cnt;

  logic                cur_cmd;
  logic [KEY_W-1:0]    cur_key;
  logic [VALUE_W-1:0]  cur_value;
  logic                periodic_due;

  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [SLOT_W-1:0]      recency_rank [MAX_ENTRIES];
  logic [KEY_W-1:0]       entry_key [MAX_ENTRIES];
  logic [VALUE_W-1:0]     value_mem [MAX_ENTRIES];
  logic [CNT_W-1:0]       used_count;

  logic                hit_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [VALUE_W-1:0]  rd_data;

  logic [CNT_W-1:0]       cap_eff;
  logic                   full;
  logic [SLOT_W-1:0]      last_rank;
  logic [MAX_ENTRIES-1:0] evict_oh;
  logic                   evict_found;
  logic [MAX_ENTRIES-1:0] free_oh;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   match_found;
  logic [SLOT_W-1:0]      match_idx;
  logic                   evict_en;
  logic                   act_mru;
  logic [SLOT_W-1:0]      mru_rank;
  logic                   mem_we;
  logic [SLOT_W-1:0]      mem_waddr;
  logic [PERIOD_W:0]      mod_trial;
  logic [PERIOD_W-1:0]    rem_next;
  logic [PERIOD_W-1:0]    op_count_next;
  logic [PERIOD_W-1:0]    phase_next;

  always_comb begin
    if (active_capacity == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(active_capacity) > MAX_ENTRIES) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(active_capacity);
    end
  end

  assign full      = (used_count >= cap_eff);
  assign last_rank = SLOT_W'(used_count - CNT_W'(1));

  always_comb begin
    evict_oh    = '0;
    evict_found = 1'b0;
    free_oh     = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (entry_valid[i] && recency_rank[i] == last_rank && !evict_found) begin
        evict_oh[i] = 1'b1;
        evict_found = 1'b1;
      end
      if (!entry_valid[i] && !free_found) begin
        free_oh[i] = 1'b1;
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (entry_valid[i] && entry_key[i] == cur_key && !match_found) begin
        match_found = 1'b1;
        match_idx   = SLOT_W'(i);
      end
    end
  end

  assign evict_en = ((ctl.periodic_evict && periodic_due) ||
                     (ctl.act && !hit_r && cur_cmd == CMD_PUT && full)) &&
                    used_count != '0 && evict_found;
  assign act_mru  = ctl.act && hit_r;
  assign mru_rank = recency_rank[slot_r];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      used_count  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (evict_en && evict_oh[i]) begin
          entry_valid[i]  <= 1'b0;
          recency_rank[i] <= '0;
        end else if (act_mru) begin
          if (SLOT_W'(i) == slot_r) begin
            recency_rank[i] <= '0;
          end else if (entry_valid[i] && recency_rank[i] < mru_rank) begin
            recency_rank[i] <= recency_rank[i] + SLOT_W'(1);
          end
        end else if (ctl.insert) begin
          if (entry_valid[i]) begin
            recency_rank[i] <= recency_rank[i] + SLOT_W'(1);
          end else if (free_oh[i]) begin
            entry_valid[i]  <= 1'b1;
            recency_rank[i] <= '0;
          end
        end
      end
      if (evict_en) begin
        used_count <= used_count - CNT_W'(1);
      end else if (ctl.insert && free_found) begin
        used_count <= used_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (ctl.insert && free_oh[i]) begin
        entry_key[i] <= cur_key;
      end
    end
  end

  assign mem_we    = (ctl.act && hit_r && cur_cmd == CMD_PUT) ||
                     (ctl.insert && free_found);
  assign mem_waddr = ctl.insert ? free_idx : slot_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[mem_waddr] <= cur_value;
    end
    if (ctl.act) begin
      rd_data <= value_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cur_cmd   <= cmd;
      cur_key   <= key;
      cur_value <= value;
    end
    if (ctl.lookup) begin
      hit_r  <= match_found;
      slot_r <= match_idx;
    end
  end

  assign mod_trial = {rem, op_count[mod_cnt]};
  assign rem_next  = (mod_trial >= {1'b0, evict_period}) ?
                     PERIOD_W'(mod_trial - {1'b0, evict_period}) :
                     PERIOD_W'(mod_trial);

  assign op_count_next = op_count + PERIOD_W'(1);

  always_comb begin
    if (op_count_next == '0) begin
      phase_next = '0;
    end else if (phase + PERIOD_W'(1) == evict_period) begin
      phase_next = '0;
    end else begin
      phase_next = phase + PERIOD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_capacity <= CAP_RESET;
      evict_period    <= '0;
      op_count        <= '0;
      phase           <= '0;
      periodic_due    <= 1'b0;
      mod_cnt         <= '0;
      rem             <= '0;
    end else begin
      if (ctl.cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE_CAPACITY: active_capacity <= cfg_data[CAP_W-1:0];
          REG_EVICT_PERIOD:    evict_period    <= cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (ctl.mod_start) begin
        rem     <= '0;
        mod_cnt <= '1;
      end else if (ctl.mod_step) begin
        rem     <= rem_next;
        mod_cnt <= mod_cnt - MOD_CNT_W'(1);
        if (mod_cnt == '0) begin
          phase <= rem_next;
        end
      end
      if (ctl.accept) begin
        periodic_due <= evict_period != '0 && op_count != '0 && phase == '0;
        op_count     <= op_count_next;
        phase        <= phase_next;
      end
    end
  end

  assign sts.is_get   = (cur_cmd == CMD_GET);
  assign sts.hit      = hit_r;
  assign sts.mod_last = (mod_cnt == '0);

  assign hit        = hit_r;
  assign read_value = hit_r ? rd_data : '1;

endmodule

### sv/lruc_ctrl.sv
// ----------------------------------------------------------------------------
// lruc_ctrl
// Sequencer for one request: periodic eviction, lookup, action, insertion and
// response, plus the phase recompute after a period write.
// ----------------------------------------------------------------------------
module lruc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lruc_pkg::CFG_IDX_W-1:0] cfg_index,
  output lruc_pkg::ctrl_cmd_t            ctl,
  input  lruc_pkg::ctrl_sts_t            sts
);
  import lruc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PEVICT = 7'b0000010,
    ST_LOOKUP = 7'b0000100,
    ST_ACT    = 7'b0001000,
    ST_INSERT = 7'b0010000,
    ST_RESP   = 7'b0100000,
    ST_MOD    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   period_wr;

  assign cfg_ready = (state == ST_IDLE) && !start;
  assign busy      = (state != ST_IDLE);
  assign done      = (state == ST_RESP);
  assign period_wr = cfg_valid && cfg_ready && cfg_index == REG_EVICT_PERIOD;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_PEVICT;
        end else if (period_wr) begin
          state_next = ST_MOD;
        end
      end
      ST_PEVICT: state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_ACT;
      ST_ACT: begin
        if (sts.is_get) begin
          state_next = ST_RESP;
        end else if (!sts.hit) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_RESP:   state_next = ST_IDLE;
      ST_MOD: begin
        if (sts.mod_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctl.cfg_we         = cfg_valid && cfg_ready;
  assign ctl.accept         = (state == ST_IDLE) && start;
  assign ctl.periodic_evict = (state == ST_PEVICT);
  assign ctl.lookup         = (state == ST_LOOKUP);
  assign ctl.act            = (state == ST_ACT);
  assign ctl.insert         = (state == ST_INSERT);
  assign ctl.mod_start      = (state == ST_IDLE) && !start && period_wr;
  assign ctl.mod_step       = (state == ST_MOD);

endmodule

### sv/lru_cache_with_periodic_evict.sv
// ----------------------------------------------------------------------------
// lru_cache_with_periodic_evict
// Key-value cache with least-recently-used replacement and optional periodic
// eviction of the least recent entry.
// ----------------------------------------------------------------------------
// A request (cmd, key, value) is taken when start is high and busy is low.
// A put returns nothing; a get returns hit and read_value for one cycle with
// done high, and the receiver must take it then. After acceptance a get
// steps through periodic eviction, lookup, action and response; a put of a
// present key through periodic eviction, lookup and action; a put of a new
// key through those and insertion. Busy stays high until the sequence
// ends; all of these steps work on the shared entry table.
// Configuration registers are written over cfg_valid, cfg_ready, cfg_index
// and cfg_data while the block is idle and start is low. A write of
// evict_period starts a bit-serial remainder of the operation count by the
// new period, one bit per cycle; busy is high and no request is taken
// meanwhile.
// Reset empties the cache, clears the operation count and restores the
// registers to a capacity of 16 and a disabled eviction period.
// ----------------------------------------------------------------------------
module lru_cache_with_periodic_evict #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd,
  input  logic [lruc_pkg::KEY_W-1:0]          key,
  input  logic signed [lruc_pkg::VALUE_W-1:0] value,
  output logic                                done,
  output logic                                hit,
  output logic signed [lruc_pkg::VALUE_W-1:0] read_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lruc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lruc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import lruc_pkg::*;

  ctrl_cmd_t ctl;
  ctrl_sts_t sts;

  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .ctl       (ctl),
    .sts       (sts)
  );

  lruc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .key        (key),
    .value      (value),
    .hit        (hit),
    .read_value (read_value)
  );

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted request did not occupy the block.");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Response held for more than one cycle.");

  a_done_get : assert property (@(posedge clk) disable iff (rst)
    done |-> busy && sts.is_get)
    else $error("Response produced for a request that is not a get.");

  a_period_recompute : assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && !start && cfg_index == REG_EVICT_PERIOD |=> busy && ctl.mod_step)
    else $error("Period write did not start the phase recompute.");

endmodule
